FILE: hdl/lu_linear_system_solver_unit_defines.svh
// ---------------------------------------------------------------------------
// LU solver assertion macros
// Shared concurrent assertion forms for the LU solver RTL.
// ---------------------------------------------------------------------------
`ifndef LU_LINEAR_SYSTEM_SOLVER_UNIT_DEFINES_SVH
`define LU_LINEAR_SYSTEM_SOLVER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LUS_ASSERT_SAME(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("LU solver check failed");

// antecedent implies consequent in the next cycle
`define LUS_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("LU solver check failed");

`endif

FILE: hdl/lusolve_pkg.sv
// ---------------------------------------------------------------------------
// LU solver package
// Input kind codes and the shared 32-bit saturation helper.
// ---------------------------------------------------------------------------
package lusolve_pkg;

    typedef enum logic [1:0] {
        KIND_MATRIX = 2'd0,
        KIND_RHS    = 2'd1,
        KIND_SOLVE  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam int WORD_W = 32;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sh0000_0000_7FFF_FFFF;
        lo = -64'sh0000_0000_8000_0000;
        if (v > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            sat32 = -32'sh8000_0000;
        end else begin
            sat32 = v[WORD_W-1:0];
        end
    endfunction

endpackage

FILE: hdl/lusolve_ram.sv
// ---------------------------------------------------------------------------
// LU solver RAM
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lusolve_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/lusolve_div.sv
// ---------------------------------------------------------------------------
// LU solver divider
// Restoring divider, (num << FRAC_BITS) / den, truncated, saturated.
// ---------------------------------------------------------------------------
module lusolve_div
    import lusolve_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [WORD_W-1:0] num,
    input  logic signed [WORD_W-1:0] den,
    output logic                     done,
    output logic signed [WORD_W-1:0] quot
);

    localparam int DW = WORD_W + FRAC_BITS;
    localparam int NW = $clog2(DW + 1);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

    dstate_t           state_reg;
    logic [DW-1:0]     dvd_reg;
    logic [WORD_W-1:0] dmag_reg;
    logic [WORD_W-1:0] rem_reg;
    logic              neg_reg;
    logic [NW-1:0]     cnt_reg;
    logic              done_reg;
    logic [WORD_W-1:0] quot_reg;

    logic [WORD_W:0]   trial;
    logic              fits;
    logic [WORD_W-1:0] num_mag;
    logic [WORD_W-1:0] den_mag;
    logic signed [63:0] q_signed;

    assign num_mag = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
    assign den_mag = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
    assign trial   = {rem_reg, dvd_reg[DW-1]};
    assign fits    = trial >= {1'b0, dmag_reg};
    assign q_signed = neg_reg ? -$signed(64'(dvd_reg)) : $signed(64'(dvd_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        dvd_reg   <= {num_mag, FRAC_BITS'(0)};
                        dmag_reg  <= den_mag;
                        neg_reg   <= num[WORD_W-1] ^ den[WORD_W-1];
                        rem_reg   <= '0;
                        cnt_reg   <= NW'(DW);
                        state_reg <= D_RUN;
                    end
                end
                D_RUN: begin
                    // one quotient bit a cycle, shifted into the dividend
                    rem_reg <= fits ? WORD_W'(trial - {1'b0, dmag_reg}) : trial[WORD_W-1:0];
                    dvd_reg <= {dvd_reg[DW-2:0], fits};
                    cnt_reg <= cnt_reg - NW'(1);
                    if (cnt_reg == NW'(1)) begin
                        state_reg <= D_FIN;
                    end
                end
                D_FIN: begin
                    quot_reg  <= sat32(q_signed);
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: hdl/lu_linear_system_solver_unit.sv
// Sequence: a load beat is written to its RAM as it is accepted; a solve runs
// factoring, then forward and back substitution, waiting on the divider for each divide.
// Throughput: one item at a time, set by the sequencer, which takes input beats only in idle.
// Results leave through ST_OUT_RD and ST_OUT_LD, at most one beat per pass.
// Reset: synchronous, active low; clears control state, size returns to 32.
// ---------------------------------------------------------------------------
// LU linear system solver
// Doolittle LU without pivoting, then forward and back substitution, in
// signed fixed point. Matrix, right-hand side and work vector live in RAMs.
// ---------------------------------------------------------------------------
`include "lu_linear_system_solver_unit_defines.svh"

module lu_linear_system_solver_unit
    import lusolve_pkg::*;
#(
    parameter int N_MAX     = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [5:0]         cfg_data,
    // input beats
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [4:0]         s_row,
    input  logic [4:0]         s_col,
    input  logic signed [31:0] s_value,
    // result beats
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_index,
    output logic signed [31:0] m_solution,
    output logic               m_last,
    output logic               m_pivot_error
);

    localparam int IW   = $clog2(N_MAX);
    localparam int CW   = $clog2(N_MAX + 1);
    localparam int MD   = N_MAX * N_MAX;
    localparam int AW   = $clog2(MD);
    localparam int NCAP = (N_MAX < 32) ? N_MAX : 32;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PIV_RD, ST_PIV_CHK, ST_L_RD, ST_L_DIV0, ST_L_DIV,
        ST_U_RD1, ST_U_RD2, ST_U_MUL, ST_U_WR, ST_L_WR,
        ST_FW_ROW, ST_FW_RD, ST_FW_MUL, ST_FW_ACC, ST_FW_B, ST_FW_WR,
        ST_BK_ROW, ST_BK_RD, ST_BK_MUL, ST_BK_ACC, ST_BK_C, ST_BK_DIV0, ST_BK_DIV,
        ST_OUT_RD, ST_OUT_LD
    } state_t;

    function automatic logic [AW-1:0] maddr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        maddr = AW'(AW'(r) * AW'(N_MAX) + AW'(c));
    endfunction

    state_t             state_reg;
    logic [5:0]         size_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      k_reg;
    logic signed [31:0] piv_reg;
    logic signed [31:0] l_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] ujk_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic               err_reg;
    logic               m_valid_reg;
    logic [4:0]         m_index_reg;
    logic signed [31:0] m_solution_reg;
    logic               m_last_reg;
    logic               m_err_reg;

    // RAM ports
    logic               mat_we;
    logic [AW-1:0]      mat_waddr;
    logic [AW-1:0]      mat_raddr;
    logic [31:0]        mat_wdata;
    logic [31:0]        mat_rdata;
    logic               rhs_we;
    logic [IW-1:0]      rhs_raddr;
    logic [31:0]        rhs_rdata;
    logic               wv_we;
    logic [IW-1:0]      wv_waddr;
    logic [IW-1:0]      wv_raddr;
    logic [31:0]        wv_wdata;
    logic [31:0]        wv_rdata;

    logic               div_start;
    logic signed [31:0] div_num;
    logic signed [31:0] div_den;
    logic               div_done;
    logic signed [31:0] div_quot;

    logic [IW-1:0]      ii;
    logic [IW-1:0]      jj;
    logic [IW-1:0]      kk;
    logic [CW-1:0]      i_inc;
    logic [CW-1:0]      j_inc;
    logic [CW-1:0]      k_inc;
    logic [CW-1:0]      n_eff;
    logic               s_fire;
    logic               load_ok;
    logic               out_free;
    logic signed [63:0] prod_sh;
    logic signed [31:0] upd_val;
    logic signed [31:0] fw_val;
    logic signed [31:0] bk_num;

    assign ii    = i_reg[IW-1:0];
    assign jj    = j_reg[IW-1:0];
    assign kk    = k_reg[IW-1:0];
    assign i_inc = i_reg + CW'(1);
    assign j_inc = j_reg + CW'(1);
    assign k_inc = k_reg + CW'(1);

    // size clamped to 1 .. NCAP
    assign n_eff = (size_reg == 6'd0) ? CW'(1)
                 : (32'(size_reg) > NCAP) ? CW'(NCAP) : CW'(size_reg);

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign load_ok   = (32'(s_row) < N_MAX) && (32'(s_col) < N_MAX);
    assign out_free  = !m_valid_reg || m_ready;

    // product back to Q format, floor rounding
    assign prod_sh = prod_reg >>> FRAC_BITS;
    assign upd_val = sat32($signed(64'($signed(ujk_reg))) - prod_sh);
    assign fw_val  = sat32($signed(64'($signed(rhs_rdata))) - acc_reg);
    assign bk_num  = sat32($signed(64'($signed(wv_rdata))) - acc_reg);

    // RAM address and write steering
    always_comb begin
        mat_we    = 1'b0;
        mat_waddr = maddr(jj, kk);
        mat_wdata = upd_val;
        mat_raddr = maddr(ii, ii);
        rhs_we    = 1'b0;
        rhs_raddr = ii;
        wv_we     = 1'b0;
        wv_waddr  = ii;
        wv_wdata  = fw_val;
        wv_raddr  = ii;
        div_start = 1'b0;
        div_num   = $signed(mat_rdata);
        div_den   = piv_reg;
        unique case (state_reg)
            ST_IDLE: begin
                mat_we    = s_fire && (s_kind == KIND_MATRIX) && load_ok;
                mat_waddr = maddr(IW'(s_row), IW'(s_col));
                mat_wdata = s_value;
                rhs_we    = s_fire && (s_kind == KIND_RHS) && (32'(s_row) < N_MAX);
            end
            ST_L_RD:   mat_raddr = maddr(jj, ii);
            ST_L_DIV0: div_start = 1'b1;
            ST_U_RD1:  mat_raddr = maddr(ii, kk);
            ST_U_RD2:  mat_raddr = maddr(jj, kk);
            ST_U_WR:   mat_we = 1'b1;
            ST_L_WR: begin
                mat_we    = 1'b1;
                mat_waddr = maddr(jj, ii);
                mat_wdata = l_reg;
            end
            ST_FW_RD, ST_BK_RD: begin
                mat_raddr = maddr(ii, jj);
                wv_raddr  = jj;
            end
            ST_FW_WR: wv_we = 1'b1;
            ST_BK_DIV0: begin
                div_start = 1'b1;
                div_num   = bk_num;
                div_den   = $signed(mat_rdata);
            end
            ST_BK_DIV: begin
                wv_we    = div_done;
                wv_wdata = div_quot;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            size_reg    <= 6'd32;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && (s_kind == KIND_SOLVE)) begin
                        n_reg     <= n_eff;
                        i_reg     <= '0;
                        err_reg   <= 1'b0;
                        state_reg <= ST_PIV_RD;
                    end
                end
                ST_PIV_RD: state_reg <= ST_PIV_CHK;
                ST_PIV_CHK: begin
                    piv_reg <= $signed(mat_rdata);
                    if (mat_rdata == 32'd0) begin
                        // zero pivot: report n error beats
                        err_reg   <= 1'b1;
                        i_reg     <= '0;
                        state_reg <= ST_OUT_RD;
                    end else if (i_inc < n_reg) begin
                        j_reg     <= i_inc;
                        state_reg <= ST_L_RD;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= ST_FW_ROW;
                    end
                end
                ST_L_RD:   state_reg <= ST_L_DIV0;
                ST_L_DIV0: state_reg <= ST_L_DIV;
                ST_L_DIV: begin
                    if (div_done) begin
                        l_reg     <= div_quot;
                        k_reg     <= i_inc;
                        state_reg <= ST_U_RD1;
                    end
                end
                ST_U_RD1: state_reg <= ST_U_RD2;
                ST_U_RD2: begin
                    t_reg     <= $signed(mat_rdata);
                    state_reg <= ST_U_MUL;
                end
                ST_U_MUL: begin
                    ujk_reg   <= $signed(mat_rdata);
                    prod_reg  <= l_reg * t_reg;
                    state_reg <= ST_U_WR;
                end
                ST_U_WR: begin
                    k_reg     <= k_inc;
                    state_reg <= (k_inc < n_reg) ? ST_U_RD1 : ST_L_WR;
                end
                ST_L_WR: begin
                    j_reg <= j_inc;
                    if (j_inc < n_reg) begin
                        state_reg <= ST_L_RD;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= ST_PIV_RD;
                    end
                end
                // forward substitution, L c = b
                ST_FW_ROW: begin
                    acc_reg   <= '0;
                    j_reg     <= '0;
                    state_reg <= (i_reg == '0) ? ST_FW_B : ST_FW_RD;
                end
                ST_FW_RD: state_reg <= ST_FW_MUL;
                ST_FW_MUL: begin
                    prod_reg  <= $signed(mat_rdata) * $signed(wv_rdata);
                    state_reg <= ST_FW_ACC;
                end
                ST_FW_ACC: begin
                    acc_reg   <= acc_reg + prod_sh;
                    j_reg     <= j_inc;
                    state_reg <= (j_inc < i_reg) ? ST_FW_RD : ST_FW_B;
                end
                ST_FW_B: state_reg <= ST_FW_WR;
                ST_FW_WR: begin
                    if (i_inc < n_reg) begin
                        i_reg     <= i_inc;
                        state_reg <= ST_FW_ROW;
                    end else begin
                        state_reg <= ST_BK_ROW;
                    end
                end
                // back substitution, U x = c
                ST_BK_ROW: begin
                    acc_reg   <= '0;
                    j_reg     <= i_inc;
                    state_reg <= (i_inc < n_reg) ? ST_BK_RD : ST_BK_C;
                end
                ST_BK_RD: state_reg <= ST_BK_MUL;
                ST_BK_MUL: begin
                    prod_reg  <= $signed(mat_rdata) * $signed(wv_rdata);
                    state_reg <= ST_BK_ACC;
                end
                ST_BK_ACC: begin
                    acc_reg   <= acc_reg + prod_sh;
                    j_reg     <= j_inc;
                    state_reg <= (j_inc < n_reg) ? ST_BK_RD : ST_BK_C;
                end
                ST_BK_C:    state_reg <= ST_BK_DIV0;
                ST_BK_DIV0: state_reg <= ST_BK_DIV;
                ST_BK_DIV: begin
                    if (div_done) begin
                        if (i_reg == '0) begin
                            state_reg <= ST_OUT_RD;
                        end else begin
                            i_reg     <= i_reg - CW'(1);
                            state_reg <= ST_BK_ROW;
                        end
                    end
                end
                // result beats
                ST_OUT_RD: begin
                    if (out_free) begin
                        state_reg <= ST_OUT_LD;
                    end
                end
                ST_OUT_LD: begin
                    m_valid_reg    <= 1'b1;
                    m_index_reg    <= 5'(i_reg);
                    m_solution_reg <= err_reg ? 32'sd0 : $signed(wv_rdata);
                    m_last_reg     <= (i_inc == n_reg);
                    m_err_reg      <= err_reg;
                    if (i_inc == n_reg) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        i_reg     <= i_inc;
                        state_reg <= ST_OUT_RD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_index       = m_index_reg;
    assign m_solution    = m_solution_reg;
    assign m_last        = m_last_reg;
    assign m_pivot_error = m_err_reg;

    lusolve_ram #(.WIDTH(32), .DEPTH(MD)) u_mat_ram (
        .aclk  (aclk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (mat_wdata),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    lusolve_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_rhs_ram (
        .aclk  (aclk),
        .we    (rhs_we),
        .waddr (IW'(s_row)),
        .wdata (s_value),
        .raddr (rhs_raddr),
        .rdata (rhs_rdata)
    );

    lusolve_ram #(.WIDTH(32), .DEPTH(N_MAX)) u_work_ram (
        .aclk  (aclk),
        .we    (wv_we),
        .waddr (wv_waddr),
        .wdata (wv_wdata),
        .raddr (wv_raddr),
        .rdata (wv_rdata)
    );

    lusolve_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // a solve beat blocks the input side on the next cycle
    `LUS_ASSERT_NEXT(a_solve_busy, aclk, aresetn, s_fire && (s_kind == KIND_SOLVE), !s_ready)
    // error beats carry zero
    `LUS_ASSERT_SAME(a_err_zero, aclk, aresetn, m_valid && m_pivot_error, m_solution == 32'sd0)
    // last beat is x[n-1]
    `LUS_ASSERT_SAME(a_last_idx, aclk, aresetn, m_valid && m_last, m_index == 5'(n_reg - CW'(1)))

endmodule

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// LU solver testbench
// Loads systems of several orders, solves them and checks every solution
// beat against a fixed-point Doolittle predictor held in the bench.
// ---------------------------------------------------------------------------
module testbench;
    import lusolve_pkg::*;

    localparam int FRAC   = 16;
    localparam int DIM    = 32;
    localparam int SETTLE = 200;       // quiet cycles before a size change and at the end
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        kind_t              kind;
        logic [4:0]         row;
        logic [4:0]         col;
        logic signed [31:0] value;
    } load_beat_t;

    typedef struct {
        logic [4:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic               pivot_error;
    } solution_beat_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [5:0]         cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [4:0]         s_row;
    logic [4:0]         s_col;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [4:0]         m_index;
    logic signed [31:0] m_solution;
    logic               m_last;
    logic               m_pivot_error;

    lu_linear_system_solver_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_row        (s_row),
        .s_col        (s_col),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_index      (m_index),
        .m_solution   (m_solution),
        .m_last       (m_last),
        .m_pivot_error(m_pivot_error)
    );

    // queues between generator, driver and checker
    load_beat_t     pending_beats[$];
    solution_beat_t expected_solutions[$];

    // predictor state: its own copy of the stores and of the size register
    int       pred_matrix[DIM][DIM];
    int       pred_rhs[DIM];
    int       pred_x[DIM];
    int       pred_size;

    // generator bookkeeping: which entries have been loaded so far
    bit       gen_mat_loaded[DIM][DIM];
    bit       gen_rhs_loaded[DIM];
    int       gen_items;

    // handshake flags, set at the rising edge and consumed at the falling edge
    bit       s_taken;
    bit       m_taken;
    bit       cfg_taken;
    int       in_gap;
    int       out_stall;
    bit       quiet;
    int       drive_count;

    int       failures;
    int       solves_seen;
    int       results_seen;
    int       pivot_errors_seen;
    longint   cycles;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // -----------------------------------------------------------------------
    // Fixed-point arithmetic of the predictor
    // -----------------------------------------------------------------------
    function automatic int sat_word(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    // exact product, shifted with floor rounding (arithmetic shift)
    function automatic longint q_mul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC;
    endfunction

    // quotient truncated toward zero, then saturated; divisor never zero here
    function automatic int q_div(int num, int den);
        longint scaled;
        scaled = longint'(num) <<< FRAC;
        return sat_word(scaled / longint'(den));
    endfunction

    // factor in place, substitute, queue the n solution beats
    task automatic solve_system();
        int             n;
        bit             ok;
        longint         acc;
        int             piv;
        int             l;
        solution_beat_t sb;
        n  = pred_size;
        if (n < 1) n = 1;
        if (n > DIM) n = DIM;
        ok = 1'b1;
        for (int i = 0; i < n && ok; i++) begin
            piv = pred_matrix[i][i];
            if (piv == 0) begin
                ok = 1'b0;
            end else begin
                for (int j = i + 1; j < n; j++) begin
                    l = q_div(pred_matrix[j][i], piv);
                    for (int k = i + 1; k < n; k++)
                        pred_matrix[j][k] = sat_word(longint'(pred_matrix[j][k])
                                                     - q_mul(l, pred_matrix[i][k]));
                    pred_matrix[j][i] = l;
                end
            end
        end
        if (ok) begin
            // forward: L c = b, unit diagonal
            for (int i = 0; i < n; i++) begin
                acc = 0;
                for (int j = 0; j < i; j++) acc += q_mul(pred_matrix[i][j], pred_x[j]);
                pred_x[i] = sat_word(longint'(pred_rhs[i]) - acc);
            end
            // back: U x = c
            for (int i = n - 1; i >= 0; i--) begin
                acc = 0;
                for (int j = i + 1; j < n; j++) acc += q_mul(pred_matrix[i][j], pred_x[j]);
                pred_x[i] = q_div(sat_word(longint'(pred_x[i]) - acc), pred_matrix[i][i]);
            end
        end
        for (int i = 0; i < n; i++) begin
            sb.index       = i[4:0];
            sb.solution    = ok ? pred_x[i] : 32'sd0;
            sb.last        = (i == n - 1);
            sb.pivot_error = !ok;
            expected_solutions.push_back(sb);
        end
        if (!ok) pivot_errors_seen++;
        solves_seen++;
    endtask

    // -----------------------------------------------------------------------
    // Generator helpers
    // -----------------------------------------------------------------------
    function automatic void queue_beat(kind_t k, int r, int c, int v);
        load_beat_t b;
        b.kind  = k;
        b.row   = r[4:0];
        b.col   = c[4:0];
        b.value = v;
        pending_beats.push_back(b);
        gen_items++;
        if (k == KIND_MATRIX) gen_mat_loaded[r][c] = 1'b1;
        if (k == KIND_RHS) gen_rhs_loaded[r] = 1'b1;
    endfunction

    // small signed value around zero, Q16.16 up to +/-2.0
    function automatic int modest_value();
        return $signed($urandom_range(0, 262144)) - 131072;
    endfunction

    // mode 0: diagonally dominant, 1: raw 32-bit noise
    function automatic int entry_value(int mode, int r, int c, int n);
        int mag;
        if (mode == 1) return $urandom;
        if (r != c) return modest_value();
        mag = n * 131072 + $urandom_range(65536, 262144);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    // load everything inside the n x n window (and its rhs) in a shuffled order
    function automatic void load_system(int n, int mode);
        int order[$];
        for (int i = 0; i < n * n + n; i++) order.push_back(i);
        order.shuffle();
        foreach (order[o]) begin
            if (order[o] < n * n)
                queue_beat(KIND_MATRIX, order[o] / n, order[o] % n,
                           entry_value(mode, order[o] / n, order[o] % n, n));
            else
                queue_beat(KIND_RHS, order[o] - n * n, 0,
                           mode == 1 ? int'($urandom) : modest_value() * 4);
        end
    endfunction

    // top up only the entries a solve of order n would read but never saw
    function automatic void fill_gaps(int n);
        for (int r = 0; r < n; r++) begin
            if (!gen_rhs_loaded[r]) queue_beat(KIND_RHS, r, 0, modest_value());
            for (int c = 0; c < n; c++)
                if (!gen_mat_loaded[r][c]) queue_beat(KIND_MATRIX, r, c, entry_value(0, r, c, n));
        end
    endfunction

    function automatic void queue_noise();
        queue_beat(KIND_NONE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
    endfunction

    function automatic int order_of(int cfg);
        if (cfg < 1) return 1;
        if (cfg > DIM) return DIM;
        return cfg;
    endfunction

    // wait until every beat is sent and every solution has come back
    task automatic drain();
        while (pending_beats.size() != 0 || s_valid || expected_solutions.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_size(int cfg);
        drain();
        cfg_data  <= cfg[5:0];
        cfg_valid <= 1'b1;
        cfg_taken  = 1'b0;
        do @(negedge aclk); while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Stimulus: directed systems first, then random phases of varying order
    // -----------------------------------------------------------------------
    initial begin
        int n;
        int cfg;
        int rewrites;
        int roll;
        int phase_sizes[$];

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_kind    = '0;
        s_row     = '0;
        s_col     = '0;
        s_value   = '0;
        m_ready   = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // order 1: zero pivot, then the word extremes
        write_size(1);
        queue_beat(KIND_MATRIX, 0, 0, 0);
        queue_beat(KIND_RHS, 0, 0, 32'sh7FFF_FFFF);
        queue_beat(KIND_SOLVE, 0, 0, 0);
        queue_beat(KIND_MATRIX, 0, 0, 32'sh7FFF_FFFF);
        queue_beat(KIND_RHS, 0, 0, 32'sh8000_0000);
        queue_beat(KIND_SOLVE, 0, 0, 0);
        queue_beat(KIND_MATRIX, 0, 0, 32'sh8000_0000);
        queue_beat(KIND_NONE, 31, 31, 32'shFFFF_FFFF);
        queue_beat(KIND_SOLVE, 31, 31, 32'shFFFF_FFFF);
        queue_beat(KIND_MATRIX, 0, 0, 1);   // tiny pivot saturates the quotient
        queue_beat(KIND_SOLVE, 0, 0, 0);

        // order 2: unit lower triangular, repeated solve, late zero pivot
        write_size(2);
        queue_beat(KIND_MATRIX, 0, 0, 32'sh0001_0000);
        queue_beat(KIND_MATRIX, 0, 1, 0);
        queue_beat(KIND_MATRIX, 1, 0, 32'sh7FFF_FFFF);
        queue_beat(KIND_MATRIX, 1, 1, 32'sh0001_0000);
        queue_beat(KIND_RHS, 0, 0, 32'sh0003_0000);
        queue_beat(KIND_RHS, 1, 0, 32'sh8000_0000);
        queue_beat(KIND_SOLVE, 0, 0, 0);
        queue_beat(KIND_SOLVE, 0, 0, 0);    // factors the factored store again
        queue_beat(KIND_MATRIX, 1, 0, 32'sh0001_0000);
        queue_beat(KIND_MATRIX, 1, 1, 32'sh0001_0000);
        queue_beat(KIND_MATRIX, 0, 1, 32'sh0001_0000);
        queue_beat(KIND_MATRIX, 0, 0, 32'sh0001_0000);
        queue_beat(KIND_SOLVE, 0, 0, 0);    // second pivot cancels to zero

        // size register at zero clamps to order 1
        write_size(0);
        queue_beat(KIND_SOLVE, 0, 0, 0);

        // random phases, small orders mostly
        phase_sizes = '{3};
        while (gen_items < 340 || phase_sizes.size() != 0) begin
            if (phase_sizes.size() != 0) cfg = phase_sizes.pop_front();
            else cfg = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 8) : $urandom_range(1, 5);
            write_size(cfg);
            n = order_of(cfg);
            if (n == DIM) begin
                load_system(n, 0);
                queue_beat(KIND_SOLVE, 0, 0, 0);
                continue;
            end
            load_system(n, 0);
            fill_gaps(n);
            repeat ($urandom_range(2, 4)) begin
                roll = $urandom_range(0, 99);
                if (roll < 60) begin
                    load_system(n, 0);
                end else if (roll < 72) begin
                    load_system(n, 1);
                end else if (roll < 84) begin
                    load_system(n, 0);
                    queue_beat(KIND_MATRIX, $urandom_range(0, n - 1) * 0 + 0, 0, 0);
                    n = n;  // leading pivot zero
                end else if (roll < 92) begin
                    rewrites = $urandom_range(1, n);
                    repeat (rewrites) begin
                        int r;
                        r = $urandom_range(0, n - 1);
                        queue_beat(KIND_MATRIX, r, $urandom_range(0, n - 1), modest_value());
                    end
                end
                // otherwise: solve again on the already factored store
                if ($urandom_range(0, 9) == 0) queue_noise();
                queue_beat(KIND_SOLVE, $urandom_range(0, 31), $urandom_range(0, 31), $urandom);
            end
        end

        drain();
        $display("Covered %0d solves (%0d with a zero pivot), %0d solution beats checked.",
                 solves_seen, pivot_errors_seen, results_seen);
        $display("Orders 1 to 8, size register at 0 included.");
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // -----------------------------------------------------------------------
    // Input driver: one beat in flight, random gap after each accepted beat
    // -----------------------------------------------------------------------
    always @(negedge aclk) begin
        logic       nv;
        load_beat_t b;
        nv = s_valid;
        if (s_valid && s_taken) begin
            nv      = 1'b0;
            s_taken = 1'b0;
        end
        if (!nv && aresetn) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (pending_beats.size() != 0) begin
                b = pending_beats.pop_front();
                s_kind  <= b.kind;
                s_row   <= b.row;
                s_col   <= b.col;
                s_value <= b.value;
                nv       = 1'b1;
                drive_count++;
                if (drive_count % 60 == 0) quiet = !quiet;   // stretches without gaps
                in_gap = quiet ? 0 : $urandom_range(0, 16);
            end
        end
        s_valid <= nv;
    end

    // result side back-pressure: random stall after each accepted beat
    always @(negedge aclk) begin
        if (m_taken) begin
            m_taken   = 1'b0;
            out_stall = quiet ? 0 : $urandom_range(0, 16);
        end
        if (out_stall > 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    // -----------------------------------------------------------------------
    // Rising-edge monitor: predictor update on input beats, checks on results
    // -----------------------------------------------------------------------
    always @(posedge aclk) begin
        solution_beat_t e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (!aresetn) begin
            pred_size = 32;
        end else begin
            if (cfg_valid && cfg_ready) begin
                pred_size = cfg_data;
                cfg_taken = 1'b1;
            end
            if (s_valid && s_ready) begin
                s_taken = 1'b1;
                case (s_kind)
                    KIND_MATRIX: pred_matrix[s_row][s_col] = s_value;
                    KIND_RHS:    pred_rhs[s_row] = s_value;
                    KIND_SOLVE:  solve_system();
                    default:     ;
                endcase
            end
            if (m_valid && m_ready) begin
                m_taken = 1'b1;
                results_seen++;
                if (expected_solutions.size() == 0) begin
                    $error("solution beat index %0d with nothing expected", m_index);
                    failures++;
                end else begin
                    e = expected_solutions.pop_front();
                    if (m_index !== e.index) begin
                        $error("index: expected %0d, got %0d", e.index, m_index);
                        failures++;
                    end
                    if (m_solution !== e.solution) begin
                        $error("solution: expected %0d, got %0d", e.solution, m_solution);
                        failures++;
                    end
                    if (m_last !== e.last) begin
                        $error("last: expected %0b, got %0b", e.last, m_last);
                        failures++;
                    end
                    if (m_pivot_error !== e.pivot_error) begin
                        $error("pivot_error: expected %0b, got %0b",
                               e.pivot_error, m_pivot_error);
                        failures++;
                    end
                end
            end
        end
    end

endmodule
